// ----- src/utf8d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned RepCntW = 2;

  localparam int unsigned JobDepth = 4;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);
  localparam int unsigned JobCntW  = $clog2(JobDepth + 1);

  localparam logic [CpW-1:0] ReplacementCp = CpW'(24'h00FFFD);

  // lead and continuation byte classes
  localparam logic [ByteW-1:0] MaskCont  = 8'hC0;
  localparam logic [ByteW-1:0] PatCont   = 8'h80;
  localparam logic [ByteW-1:0] MaskLead2 = 8'hE0;
  localparam logic [ByteW-1:0] PatLead2  = 8'hC0;
  localparam logic [ByteW-1:0] MaskLead3 = 8'hF0;
  localparam logic [ByteW-1:0] PatLead3  = 8'hE0;
  localparam logic [ByteW-1:0] MaskLead4 = 8'hF8;
  localparam logic [ByteW-1:0] PatLead4  = 8'hF0;

  // One job per byte with output: replacements, then an optional tail result.
  typedef struct packed {
    logic [RepCntW-1:0] rep_cnt;
    logic               tail_vld;
    logic [CpW-1:0]     tail_cp;
    logic               tail_repl;
  } job_t;

endpackage
`default_nettype wire

// ----- src/utf8d_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_front
// Byte classifier: tracks the open sequence; a byte with output becomes a job.
// ----------------------------------------------------------------------------
module utf8d_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              byte_i,
  output logic                    job_vld_o,
  output utf8d_pkg::job_t         job_o
);
  import utf8d_pkg::*;

  logic [CpW-1:0] pv_q, pv_d;
  logic [1:0]     need_q, need_d;
  logic [1:0]     taken_q, taken_d;
  logic [CpW-1:0] pv_shift;
  logic           is_cont;
  logic           fresh;
  job_t           job;

  assign is_cont  = (byte_i & MaskCont) == PatCont;
  assign pv_shift = {pv_q[CpW-7:0], byte_i[5:0]};

  always_comb begin
    pv_d    = pv_q;
    need_d  = need_q;
    taken_d = taken_q;
    job     = '0;
    fresh   = 1'b0;
    if (need_q != 2'd0) begin
      if (is_cont) begin
        if (need_q == 2'd1) begin
          job.tail_vld = 1'b1;
          job.tail_cp  = pv_shift;
          pv_d         = '0;
          need_d       = 2'd0;
          taken_d      = 2'd0;
        end else begin
          pv_d    = pv_shift;
          need_d  = need_q - 2'd1;
          taken_d = taken_q + 2'd1;
        end
      end else begin
        // broken sequence: one for the lead, one per continuation taken
        job.rep_cnt = (taken_q > 2'd2) ? 2'd3 : taken_q + 2'd1;
        pv_d    = '0;
        need_d  = 2'd0;
        taken_d = 2'd0;
        fresh   = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (!byte_i[7]) begin
        job.tail_vld = 1'b1;
        job.tail_cp  = CpW'(byte_i);
      end else if ((byte_i & MaskLead2) == PatLead2) begin
        pv_d    = CpW'(byte_i[4:0]);
        need_d  = 2'd1;
        taken_d = 2'd0;
      end else if ((byte_i & MaskLead3) == PatLead3) begin
        pv_d    = CpW'(byte_i[3:0]);
        need_d  = 2'd2;
        taken_d = 2'd0;
      end else if ((byte_i & MaskLead4) == PatLead4) begin
        pv_d    = CpW'(byte_i[2:0]);
        need_d  = 2'd3;
        taken_d = 2'd0;
      end else begin
        job.tail_vld  = 1'b1;
        job.tail_cp   = ReplacementCp;
        job.tail_repl = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '0;
      need_q  <= '0;
      taken_q <= '0;
    end else if (accept_i) begin
      pv_q    <= pv_d;
      need_q  <= need_d;
      taken_q <= taken_d;
    end
  end

  assign job_vld_o = accept_i && (job.tail_vld || (job.rep_cnt != '0));
  assign job_o     = job;

endmodule
`default_nettype wire

// ----- src/utf8d_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_fifo
// Short job queue between the byte classifier and the result sequencer.
// ----------------------------------------------------------------------------
module utf8d_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  utf8d_pkg::job_t job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output utf8d_pkg::job_t job_o
);
  import utf8d_pkg::*;

  job_t               mem_q [JobDepth];
  logic [JobPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JobCntW-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == JobCntW'(JobDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + JobCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - JobCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + JobPtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + JobPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/utf8d_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_back
// Result sequencer: expands the head job into result beats, one per cycle with pop.
// ----------------------------------------------------------------------------
module utf8d_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_empty_i,
  input  utf8d_pkg::job_t            job_i,
  output logic                       job_pop_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [utf8d_pkg::CpW-1:0]  code_point_o,
  output logic                       is_replacement_o,
  output logic                       last_of_run_o
);
  import utf8d_pkg::*;

  logic           out_vld_q;
  logic [CpW-1:0] cp_q;
  logic           repl_q, last_q;
  logic [1:0]     idx_q;
  logic           load;
  logic           in_reps;
  logic [CpW-1:0] nxt_cp;
  logic           nxt_repl, nxt_last;

  assign load    = !job_empty_i && (!out_vld_q || pop_i);
  assign in_reps = idx_q < job_i.rep_cnt;

  always_comb begin
    if (in_reps) begin
      nxt_cp   = ReplacementCp;
      nxt_repl = 1'b1;
      nxt_last = (idx_q == (job_i.rep_cnt - 2'd1)) && !job_i.tail_vld;
    end else begin
      nxt_cp   = job_i.tail_cp;
      nxt_repl = job_i.tail_repl;
      nxt_last = 1'b1;
    end
  end

  assign job_pop_o = load && nxt_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        idx_q     <= nxt_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= nxt_cp;
      repl_q <= nxt_repl;
      last_q <= nxt_last;
    end
  end

  assign empty_o          = !out_vld_q;
  assign code_point_o     = cp_q;
  assign is_replacement_o = repl_q;
  assign last_of_run_o    = last_q;

endmodule
`default_nettype wire

// ----- src/utf8_codepoint_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// UTF-8 byte stream to code point decoder with queue-style ports.
// ----------------------------------------------------------------------------
// Push one text byte per cycle while full is low; code points come out in
// order while empty is low and are taken with pop. A plain byte or a closing
// continuation yields one beat, lead bytes and inner continuations none. A
// broken sequence yields one U+FFFD per byte already taken plus the fresh
// result, if any, of the offending byte, up to four beats, drained at one
// beat per cycle by the result sequencer while pop is held, so a sustained
// rate of one byte per cycle holds except for those error bursts, which the
// four-entry job queue absorbs. No overlong or surrogate checking is done.
module utf8_codepoint_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 text_byte_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [utf8d_pkg::CpW-1:0]  code_point_o,
  output logic                       is_replacement_o,
  output logic                       last_of_run_o
);
  import utf8d_pkg::*;

  logic accept;
  logic job_vld;
  job_t job_in, job_head;
  logic job_empty, job_pop;

  assign accept = push && !full;

  utf8d_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_i    (text_byte_i),
    .job_vld_o (job_vld),
    .job_o     (job_in)
  );

  utf8d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_vld),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .job_o   (job_head)
  );

  utf8d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_empty_i      (job_empty),
    .job_i            (job_head),
    .job_pop_o        (job_pop),
    .empty_o          (empty),
    .pop_i            (pop),
    .code_point_o     (code_point_o),
    .is_replacement_o (is_replacement_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule
`default_nettype wire

// ----- src/utf8d_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks for the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [utf8d_pkg::CpW-1:0]  code_point_o,
  input  logic                       is_replacement_o,
  input  logic                       last_of_run_o
);
  import utf8d_pkg::*;

  // an error beat always carries U+FFFD
  a_repl_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_replacement_o) |-> (code_point_o == ReplacementCp))
    else $error("replacement beat without U+FFFD");

  // only the final beat of a byte can be a real code point
  a_good_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !is_replacement_o) |-> last_of_run_o)
    else $error("decoded code point not marked last");

  // a run continues without a gap once started; the tail may be a real code point
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_of_run_o) |=> !empty)
    else $error("run broken after a non-last beat");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(code_point_o) && $stable(last_of_run_o)))
    else $error("result beat changed while stalled");

endmodule

bind utf8_codepoint_decoder utf8d_checker u_utf8d_checker (.*);
`default_nettype wire
